/* sv/tvt_pkg.sv */
// ----------------------------------------------------------------------------
// Thermistor converter package
// Shared widths, payload structs, codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package tvt_pkg;

  localparam int LOG_FRACTION_BITS = 16;
  localparam int LEVEL_WIDTH       = 16;

  // Level bits actually taken from the 16-bit port fields
  localparam int LV_W   = (LEVEL_WIDTH < 16) ? LEVEL_WIDTH : 16;
  localparam int RS_W   = 22;
  localparam int X_W    = LV_W + RS_W;
  localparam int N_W    = $clog2(X_W);
  localparam int LN_W   = N_W + LOG_FRACTION_BITS;
  localparam int BNUM_W = 23 + LOG_FRACTION_BITS;
  localparam int DIV_W  = (BNUM_W > X_W) ? BNUM_W + 1 : X_W + 1;
  localparam int D_W    = DIV_W + 1;
  localparam int TK_W   = (DIV_W > 41) ? DIV_W : 41;
  localparam int T_W    = TK_W + 1;
  localparam int P_W    = T_W + 16;
  localparam int C_W    = P_W - 11;

  localparam logic [31:0]         LN2_Q32        = 32'd2977044472;
  localparam logic [15:0]         ZERO_C_CK      = 16'd27315;
  localparam logic [TK_W-1:0]     RAW_CAP_CK     = TK_W'(64'd1 << 40);
  localparam logic signed [23:0]  SENTINEL_CENTI = -24'sd99900;
  localparam logic signed [23:0]  TEMP_MAX       = 24'sh7FFFFF;
  localparam logic signed [23:0]  TEMP_MIN       = 24'sh800000;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_LIMIT = 2'd1,
    ST_OPEN  = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_SERIES_RES  = 3'd0,
    REG_BETA        = 3'd1,
    REG_NOMINAL_RES = 3'd2,
    REG_NOMINAL_TMP = 3'd3,
    REG_GAIN        = 3'd4,
    REG_OFFSET      = 3'd5,
    REG_VALID_MIN   = 3'd6,
    REG_VALID_MAX   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] measured_level;
    logic [15:0] excitation_level;
  } tvt_in_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic [31:0]        thermistor_ohms;
    logic [1:0]         status;
  } tvt_out_t;

  // One log2 working value: mantissa in Q1.30, fraction bits so far, exponent
  typedef struct packed {
    logic [30:0]                  y;
    logic [LOG_FRACTION_BITS-1:0] f;
    logic [N_W-1:0]               n;
  } lg_t;

  function automatic logic [N_W-1:0] msb_index(input logic [X_W-1:0] x);
    logic [N_W-1:0] n;
    n = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) n = N_W'(i);
    end
    return n;
  endfunction

  // Square the mantissa, emit one fraction bit, renormalize
  function automatic lg_t log_step(input lg_t s);
    logic [61:0] sq;
    lg_t         o;
    sq  = s.y * s.y;
    o.n = s.n;
    o.f = {s.f[LOG_FRACTION_BITS-2:0], sq[61]};
    o.y = sq[61] ? sq[61:31] : sq[60:30];
    return o;
  endfunction

  // log2 value times ln 2, round to nearest
  function automatic logic [LN_W-1:0] ln_scale(input logic [N_W-1:0] n,
                                               input logic [LOG_FRACTION_BITS-1:0] f);
    logic [LN_W+31:0] p;
    p = (LN_W+32)'({n, f}) * (LN_W+32)'(LN2_Q32) + ((LN_W+32)'(1) << 31);
    return p[LN_W+31:32];
  endfunction

endpackage

/* sv/tvt_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; all stages advance together on en.
// ----------------------------------------------------------------------------
module tvt_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tvt_pkg::DIV_W-1:0] dividend,
  input  logic [tvt_pkg::DIV_W-1:0] divisor,
  output logic [tvt_pkg::DIV_W-1:0] quotient
);
  import tvt_pkg::*;

  logic [DIV_W-1:0] rem      [0:DIV_W-1];
  logic [DIV_W-1:0] quo      [0:DIV_W-1];
  logic [DIV_W-1:0] dvs      [0:DIV_W-1];
  logic [DIV_W-1:0] rem_next [0:DIV_W-1];
  logic [DIV_W-1:0] quo_next [0:DIV_W-1];
  logic [DIV_W-1:0] dvs_next [0:DIV_W-1];

  always_comb begin
    logic [DIV_W-1:0] r_in;
    logic [DIV_W-1:0] q_in;
    logic [DIV_W-1:0] d_in;
    logic [DIV_W:0]   trial;
    for (int k = 0; k < DIV_W; k++) begin
      if (k == 0) begin
        r_in = '0;
        q_in = dividend;
        d_in = divisor;
      end else begin
        r_in = rem[(k > 0) ? k - 1 : 0];
        q_in = quo[(k > 0) ? k - 1 : 0];
        d_in = dvs[(k > 0) ? k - 1 : 0];
      end
      trial = {r_in, q_in[DIV_W-1]};
      if (trial >= {1'b0, d_in}) begin
        rem_next[k] = DIV_W'(trial - {1'b0, d_in});
        quo_next[k] = {q_in[DIV_W-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[DIV_W-1:0];
        quo_next[k] = {q_in[DIV_W-2:0], 1'b0};
      end
      dvs_next[k] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_W; k++) begin
        rem[k] <= rem_next[k];
        quo[k] <= quo_next[k];
        dvs[k] <= dvs_next[k];
      end
    end
  end

  assign quotient = quo[DIV_W-1];

endmodule

/* sv/thermistor_voltage_to_temperature.sv */
// ----------------------------------------------------------------------------
// NTC thermistor divider to temperature converter
// Solves the divider for resistance, applies the beta equation and a
// gain/offset calibration, and checks the result against limits.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle; the whole pipe holds while a result stalls.
// Depth is set by two restoring divider pipelines in series (one quotient bit
// per stage): resistance and B/Tnom divide side by side, then B/denominator.
// Reset clears all valid bits and loads the register defaults; no sweep.
// ----------------------------------------------------------------------------
module thermistor_voltage_to_temperature (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  tvt_pkg::tvt_in_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output tvt_pkg::tvt_out_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [21:0]      cfg_data
);
  import tvt_pkg::*;

  localparam int LFB    = LOG_FRACTION_BITS;
  localparam int S_NORM = 4;             // normalized mantissa
  localparam int S_LN   = 5 + LFB;       // natural log done
  localparam int S_E    = 2 + DIV_W;     // log denominator d
  localparam int S_F    = S_E + DIV_W + 1; // gain product
  localparam int S_G    = S_F + 1;       // output register

  typedef enum logic [1:0] {CLS_NORMAL, CLS_OPEN, CLS_FAULT} cls_t;

  // Sideband that travels with each sample
  typedef struct packed {
    cls_t        cls;
    logic [31:0] res;
    logic        dpos;
  } side_t;

  // Configuration registers
  logic [21:0]        series_ohms;
  logic [15:0]        beta_kelvin;
  logic [21:0]        nominal_resistance;
  logic signed [15:0] nominal_temp_centi;
  logic signed [15:0] gain_q4_12;
  logic signed [15:0] offset_centi;
  logic signed [15:0] valid_min_centi;
  logic signed [15:0] valid_max_centi;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_ohms        <= 22'd10000;
      beta_kelvin        <= 16'd3950;
      nominal_resistance <= 22'd10000;
      nominal_temp_centi <= 16'sd2500;
      gain_q4_12         <= 16'sd4096;
      offset_centi       <= 16'sd0;
      valid_min_centi    <= -16'sd4000;
      valid_max_centi    <= 16'sd12500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SERIES_RES:  series_ohms        <= cfg_data;
        REG_BETA:        beta_kelvin        <= cfg_data[15:0];
        REG_NOMINAL_RES: nominal_resistance <= cfg_data;
        REG_NOMINAL_TMP: nominal_temp_centi <= signed'(cfg_data[15:0]);
        REG_GAIN:        gain_q4_12         <= signed'(cfg_data[15:0]);
        REG_OFFSET:      offset_centi       <= signed'(cfg_data[15:0]);
        REG_VALID_MIN:   valid_min_centi    <= signed'(cfg_data[15:0]);
        REG_VALID_MAX:   valid_max_centi    <= signed'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // Pipe control: every stage advances unless the finished result is held
  logic advance;
  logic vld [1:S_G];

  assign advance      = !(vld[S_G] && result_stall);
  assign sample_stall = !advance;
  assign result_valid = vld[S_G];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= S_G; k++) vld[k] <= 1'b0;
    end else if (advance) begin
      vld[1] <= sample_valid;
      for (int k = 2; k <= S_G; k++) vld[k] <= vld[k-1];
    end
  end

  // Values derived from configuration (the user must keep them stable while samples are in flight; not enforced)
  logic [21:0]        rn_eff;
  logic signed [17:0] tnom_s;
  logic [15:0]        tnom;
  logic [22:0]        bmul;
  logic [BNUM_W-1:0]  bnum;

  assign rn_eff = (nominal_resistance == '0) ? 22'd1 : nominal_resistance;
  assign tnom_s = 18'(nominal_temp_centi) + 18'sd27315;
  assign tnom   = (tnom_s < 18'sd1) ? 16'd1 : tnom_s[15:0];
  assign bmul   = 23'(beta_kelvin) * 23'd100;
  assign bnum   = {bmul, {LFB{1'b0}}};

  // Stage 1: classify the sample, form Rs*m and e-m
  logic [LV_W-1:0] m_in;
  logic [LV_W-1:0] e_in;
  logic [X_W-1:0]  num_in;
  cls_t            cls_in;

  assign m_in   = LV_W'(sample.measured_level);
  assign e_in   = LV_W'(sample.excitation_level);
  assign num_in = m_in * series_ohms;

  always_comb begin
    if (e_in == '0 || series_ohms == '0 || m_in == '0) begin
      cls_in = CLS_FAULT;
    end else if (m_in >= e_in) begin
      cls_in = CLS_OPEN;
    end else begin
      cls_in = CLS_NORMAL;
    end
  end

  logic [X_W-1:0]  num1;
  logic [LV_W-1:0] den1;
  side_t           side [1:S_G];

  // Resistance and B/Tnom dividers start from stage 1
  logic [DIV_W-1:0] r_quo;
  logic [DIV_W-1:0] bt_quo;

  tvt_div u_res_div (
    .clk      (clk),
    .en       (advance),
    .dividend (DIV_W'(num1) + DIV_W'(den1 >> 1)),
    .divisor  (DIV_W'(den1)),
    .quotient (r_quo)
  );

  tvt_div u_bt_div (
    .clk      (clk),
    .en       (advance),
    .dividend (DIV_W'(bnum) + DIV_W'(tnom >> 1)),
    .divisor  (DIV_W'(tnom)),
    .quotient (bt_quo)
  );

  // Log path: product, exponent search, normalize, squaring chain, scale
  logic [X_W-1:0]  xa2, xb2, xa3, xb3;
  logic [N_W-1:0]  na3, nb3;
  lg_t             lga [S_NORM:S_NORM+LFB];
  lg_t             lgb [S_NORM:S_NORM+LFB];
  logic [LN_W-1:0] lna [S_LN:S_E-1];
  logic [LN_W-1:0] lnb [S_LN:S_E-1];
  logic [X_W+29:0] wide_a, wide_b;

  assign wide_a = {xa3, 30'd0} >> na3;
  assign wide_b = {xb3, 30'd0} >> nb3;

  // Stage E: beta denominator d = ln(Rs*m) - ln((e-m)*Rnom) + B/Tnom
  logic signed [D_W-1:0] d_next;
  logic signed [D_W-1:0] d;
  logic [31:0]           res_sat;

  assign d_next  = signed'(D_W'(lna[S_E-1])) - signed'(D_W'(lnb[S_E-1]))
                 + signed'(D_W'(bt_quo));
  assign res_sat = (r_quo > DIV_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : r_quo[31:0];

  logic [DIV_W-1:0] tk_quo;

  tvt_div u_tk_div (
    .clk      (clk),
    .en       (advance),
    .dividend (DIV_W'(bnum) + DIV_W'(d[D_W-1:1])),
    .divisor  (d[DIV_W-1:0]),
    .quotient (tk_quo)
  );

  // Stage F: cap the raw kelvin value, go to Celsius, apply gain
  logic [TK_W-1:0]       tk_sel;
  logic signed [T_W-1:0] t_centi;
  logic signed [P_W-1:0] prod;

  always_comb begin
    if (beta_kelvin == '0) begin
      tk_sel = '0;
    end else if (!side[S_F-1].dpos || TK_W'(tk_quo) > RAW_CAP_CK) begin
      tk_sel = RAW_CAP_CK;
    end else begin
      tk_sel = TK_W'(tk_quo);
    end
    if (side[S_F-1].cls == CLS_OPEN) begin
      t_centi = -signed'(T_W'(ZERO_C_CK));
    end else begin
      t_centi = signed'(T_W'(tk_sel)) - signed'(T_W'(ZERO_C_CK));
    end
  end

  // Stage G: round the gain product, add offset, limit check, saturate
  logic signed [P_W-1:0] prod_rnd;
  logic signed [C_W-1:0] cal;
  logic signed [23:0]    cal_sat;
  status_t               lim_status;
  tvt_out_t              result_next;

  always_comb begin
    prod_rnd = (prod + P_W'(2048)) >>> 12;
    cal      = C_W'(prod_rnd) + C_W'(offset_centi);
    if (cal > C_W'(TEMP_MAX)) begin
      cal_sat = TEMP_MAX;
    end else if (cal < C_W'(TEMP_MIN)) begin
      cal_sat = TEMP_MIN;
    end else begin
      cal_sat = 24'(cal);
    end
    if (cal >= C_W'(valid_min_centi) && cal <= C_W'(valid_max_centi)) begin
      lim_status = ST_VALID;
    end else begin
      lim_status = ST_LIMIT;
    end
    case (side[S_G-1].cls)
      CLS_FAULT: begin
        result_next.temperature_centi = SENTINEL_CENTI;
        result_next.thermistor_ohms   = '0;
        result_next.status            = ST_FAULT;
      end
      CLS_OPEN: begin
        result_next.temperature_centi = cal_sat;
        result_next.thermistor_ohms   = 32'hFFFFFFFF;
        result_next.status            = ST_OPEN;
      end
      default: begin
        result_next.temperature_centi = cal_sat;
        result_next.thermistor_ohms   = side[S_G-1].res;
        result_next.status            = lim_status;
      end
    endcase
  end

  // Payload stages: no reset, hold whenever the pipe holds
  always_ff @(posedge clk) begin
    if (advance) begin
      num1    <= num_in;
      den1    <= e_in - m_in;
      side[1] <= '{cls: cls_in, res: '0, dpos: 1'b0};
      for (int k = 2; k <= S_G; k++) begin
        if (k != S_E) side[k] <= side[k-1];
      end
      // Attach the rounded resistance and the sign of d on entry to stage E
      side[S_E] <= '{cls: side[S_E-1].cls, res: res_sat, dpos: (d_next > 0)};

      xa2 <= num1;
      xb2 <= den1 * rn_eff;
      xa3 <= xa2;
      xb3 <= xb2;
      na3 <= msb_index(xa2);
      nb3 <= msb_index(xb2);

      lga[S_NORM] <= '{y: wide_a[30:0], f: '0, n: na3};
      lgb[S_NORM] <= '{y: wide_b[30:0], f: '0, n: nb3};
      for (int k = S_NORM + 1; k <= S_NORM + LFB; k++) begin
        lga[k] <= log_step(lga[k-1]);
        lgb[k] <= log_step(lgb[k-1]);
      end

      lna[S_LN] <= ln_scale(lga[S_NORM+LFB].n, lga[S_NORM+LFB].f);
      lnb[S_LN] <= ln_scale(lgb[S_NORM+LFB].n, lgb[S_NORM+LFB].f);
      for (int k = S_LN + 1; k <= S_E - 1; k++) begin
        lna[k] <= lna[k-1];
        lnb[k] <= lnb[k-1];
      end

      d      <= d_next;
      prod   <= P_W'(t_centi) * P_W'(gain_q4_12);
      result <= result_next;
    end
  end

endmodule

/* sv/tvt_chk.sv */
// ----------------------------------------------------------------------------
// Thermistor converter port checker
// Watches the top-level ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
module tvt_chk (
  input logic              clk,
  input logic              rst,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input tvt_pkg::tvt_out_t result
);
  import tvt_pkg::*;

  // Hold a stalled result unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Reset drops any pending result
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Input back-pressure only comes from a held result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without a held result");

  // Fault results carry the sentinel and zero resistance
  a_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_FAULT |->
      result.thermistor_ohms == 32'd0 && result.temperature_centi == SENTINEL_CENTI)
    else $error("fault result with bad payload");

  // Open circuit reports full-scale resistance
  a_open: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OPEN |-> result.thermistor_ohms == 32'hFFFFFFFF)
    else $error("open circuit without full-scale resistance");

endmodule

bind thermistor_voltage_to_temperature tvt_chk u_tvt_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
